@@ hw/rtl/capture_period_frequency_meter_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the capture period frequency meter
// Concurrent checks that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef CAPTURE_PERIOD_FREQUENCY_METER_UNIT_ASSERT_SVH
`define CAPTURE_PERIOD_FREQUENCY_METER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is active.
`define CPFM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cpfm assertion failed");
// Next-cycle implication, disabled while reset is active.
`define CPFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cpfm assertion failed");
`else
`define CPFM_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define CPFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/cpfm_pkg.sv @@
// ----------------------------------------------------------------------------
// Capture period frequency meter package
// Shared types and constants of the frequency meter.
// ----------------------------------------------------------------------------
package cpfm_pkg;

    localparam int MAX_CHANNELS = 4;
    localparam int DIV_STEPS    = 48;

    localparam logic [1:0] CFG_CHANNEL_ENABLE = 2'd0;
    localparam logic [1:0] CFG_MIN_COUNT      = 2'd1;
    localparam logic [1:0] CFG_TICK_RATE_HZ   = 2'd2;

    localparam logic REQ_CAPTURE = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    typedef struct packed {
        logic [15:0] last_capture;
        logic [31:0] period_sum;
        logic [15:0] period_count;
    } t_entry;

endpackage

@@ hw/rtl/capture_period_frequency_meter_unit.sv @@
// ----------------------------------------------------------------------------
// Capture period frequency meter
// Averages input-capture periods per channel and publishes frequencies.
// ----------------------------------------------------------------------------
// The input stream carries one beat per capture timestamp or publish tick;
// tuser selects the kind (0 capture, 1 tick). A capture beat updates the
// channel entry in the state memory with a read, modify and write back.
// A tick scans every channel one at a time; each channel costs a memory
// read and an evaluation, and a publishing channel adds a restoring divider
// run and a write back, so the divider run sets the length of a tick.
// Only one beat is in work at a time; the input is ready again when the
// item is finished. Results leave through an output register; the last one
// of a tick is held back until the scan ends so that tlast can be set. When
// the receiver stalls, the scan waits in front of the output register.
// Reset clears the configuration to its defaults and marks every memory
// entry empty, so that it reads as zero; no clearing pass is needed.
// The configuration port is always ready.
module capture_period_frequency_meter_unit
    import cpfm_pkg::*;
#(
    parameter int CHANNELS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // channel [1:0], capture_value [17:2]
    input  logic        i_s_tuser,   // req_type [0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // out_channel [1:0], frequency_q8 [33:2]
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    localparam int NUM_ACT = (CHANNELS < MAX_CHANNELS) ? CHANNELS : MAX_CHANNELS;
    localparam int AW      = (NUM_ACT > 1) ? $clog2(NUM_ACT) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CAP  = 3'd1;
    localparam logic [2:0] S_TRD  = 3'd2;
    localparam logic [2:0] S_TEV  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_PUB  = 3'd5;
    localparam logic [2:0] S_NEXT = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]         r_state, n_state;
    logic [3:0]         r_enable;
    logic [15:0]        r_min;
    logic [23:0]        r_rate;
    logic [NUM_ACT-1:0] r_cap_vld, n_cap_vld;
    logic [NUM_ACT-1:0] r_mem_vld;
    logic [AW-1:0]      r_ch, n_ch;
    logic [15:0]        r_val, n_val;
    logic [AW-1:0]      r_idx, n_idx;
    logic [47:0]        r_num, n_num;
    logic [31:0]        r_rem, n_rem;
    logic [31:0]        r_dsum, n_dsum;
    logic [5:0]         r_cnt, n_cnt;
    logic               r_hold_vld, n_hold_vld;
    logic [1:0]         r_hold_ch, n_hold_ch;
    logic [31:0]        r_hold_freq, n_hold_freq;
    logic               r_out_vld, n_out_vld;
    logic [1:0]         r_out_ch, n_out_ch;
    logic [31:0]        r_out_freq, n_out_freq;
    logic               r_out_last, n_out_last;

    t_entry             r_mem [NUM_ACT];
    t_entry             r_rd;
    logic               r_rd_ok;
    t_entry             rd_ent;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    t_entry             wr_data;
    logic               mem_we;

    logic               in_acc;
    logic [1:0]         in_ch;
    logic [15:0]        in_val;
    logic               in_ch_ok;
    logic               out_busy;
    logic [15:0]        period;
    logic [32:0]        sum_ext;
    logic [32:0]        rem_sh;
    logic               q_bit;
    logic [31:0]        freq;
    logic [39:0]        prod;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign in_ch       = i_s_tdata[1:0];
    assign in_val      = i_s_tdata[17:2];
    assign in_ch_ok    = (32'(in_ch) < NUM_ACT) && r_enable[in_ch];
    assign out_busy    = r_out_vld && !i_m_tready;

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {6'd0, r_out_freq, r_out_ch};
    assign o_m_tlast  = r_out_last;

    assign rd_addr = (r_state == S_IDLE) ? in_ch[AW-1:0] : r_idx;
    assign wr_addr = (r_state == S_CAP) ? r_ch : r_idx;
    assign rd_ent  = r_rd_ok ? r_rd : '0;

    assign period  = r_val - rd_ent.last_capture;
    assign sum_ext = {1'b0, rd_ent.period_sum} + {17'd0, period};
    assign rem_sh  = {r_rem, r_num[47]};
    assign q_bit   = (rem_sh >= {1'b0, r_dsum});
    assign prod    = r_rate * rd_ent.period_count;

    always_comb begin
        if (r_dsum == '0 || r_num[47:32] != '0) begin
            freq = '1;
        end else begin
            freq = r_num[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= '0;
            r_min    <= 16'd1;
            r_rate   <= 24'd78125;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CHANNEL_ENABLE: r_enable <= i_cfg_data[3:0];
                CFG_MIN_COUNT:      r_min    <= i_cfg_data[15:0];
                CFG_TICK_RATE_HZ:   r_rate   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd    <= r_mem[rd_addr];
        r_rd_ok <= r_mem_vld[rd_addr];
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
        end else if (mem_we) begin
            r_mem_vld[wr_addr] <= 1'b1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cap_vld   = r_cap_vld;
        n_ch        = r_ch;
        n_val       = r_val;
        n_idx       = r_idx;
        n_num       = r_num;
        n_rem       = r_rem;
        n_dsum      = r_dsum;
        n_cnt       = r_cnt;
        n_hold_vld  = r_hold_vld;
        n_hold_ch   = r_hold_ch;
        n_hold_freq = r_hold_freq;
        n_out_vld   = r_out_vld && !i_m_tready;
        n_out_ch    = r_out_ch;
        n_out_freq  = r_out_freq;
        n_out_last  = r_out_last;
        mem_we      = 1'b0;
        wr_data     = '{last_capture: rd_ent.last_capture, period_sum: '0, period_count: '0};

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_s_tuser == REQ_TICK) begin
                        n_cap_vld = '0;
                        n_idx     = '0;
                        n_state   = S_TRD;
                    end else if (in_ch_ok) begin
                        n_ch    = in_ch[AW-1:0];
                        n_val   = in_val;
                        n_state = S_CAP;
                    end
                end
            end
            S_CAP: begin
                mem_we = 1'b1;
                wr_data.last_capture = r_val;
                wr_data.period_sum   = rd_ent.period_sum;
                wr_data.period_count = rd_ent.period_count;
                if (r_cap_vld[r_ch]) begin
                    wr_data.period_sum = sum_ext[32] ? '1 : sum_ext[31:0];
                    if (rd_ent.period_count != '1) begin
                        wr_data.period_count = rd_ent.period_count + 16'd1;
                    end
                end
                n_cap_vld[r_ch] = 1'b1;
                n_state         = S_IDLE;
            end
            S_TRD: begin
                n_state = S_TEV;
            end
            S_TEV: begin
                n_state = S_NEXT;
                if (r_enable[r_idx]) begin
                    if (rd_ent.period_count == '0) begin
                        mem_we = 1'b1;
                    end else if (rd_ent.period_count >= r_min) begin
                        n_num   = {prod, 8'd0};
                        n_rem   = '0;
                        n_dsum  = rd_ent.period_sum;
                        n_cnt   = '0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_rem = q_bit ? 32'(rem_sh - {1'b0, r_dsum}) : rem_sh[31:0];
                n_num = {r_num[46:0], q_bit};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(DIV_STEPS - 1)) begin
                    n_state = S_PUB;
                end
            end
            S_PUB: begin
                if (!(r_hold_vld && out_busy)) begin
                    if (r_hold_vld) begin
                        n_out_vld  = 1'b1;
                        n_out_ch   = r_hold_ch;
                        n_out_freq = r_hold_freq;
                        n_out_last = 1'b0;
                    end
                    n_hold_vld  = 1'b1;
                    n_hold_ch   = 2'(r_idx);
                    n_hold_freq = freq;
                    mem_we      = 1'b1;
                    n_state     = S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_idx == AW'(NUM_ACT - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_TRD;
                end
            end
            S_FIN: begin
                if (!r_hold_vld) begin
                    n_state = S_IDLE;
                end else if (!out_busy) begin
                    n_out_vld  = 1'b1;
                    n_out_ch   = r_hold_ch;
                    n_out_freq = r_hold_freq;
                    n_out_last = 1'b1;
                    n_hold_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cap_vld  <= '0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_idx      <= '0;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_cap_vld  <= n_cap_vld;
            r_hold_vld <= n_hold_vld;
            r_out_vld  <= n_out_vld;
            r_idx      <= n_idx;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch        <= n_ch;
        r_val       <= n_val;
        r_num       <= n_num;
        r_rem       <= n_rem;
        r_dsum      <= n_dsum;
        r_hold_ch   <= n_hold_ch;
        r_hold_freq <= n_hold_freq;
        r_out_ch    <= n_out_ch;
        r_out_freq  <= n_out_freq;
        r_out_last  <= n_out_last;
    end

`include "capture_period_frequency_meter_unit_assert.svh"

    `CPFM_ASSERT_NEXT(a_tick_clears_valid, i_clk, i_rst_n, in_acc && (i_s_tuser == REQ_TICK), r_cap_vld == '0)
    `CPFM_ASSERT_NOW(a_idle_no_hold, i_clk, i_rst_n, r_state == S_IDLE, !r_hold_vld)
    `CPFM_ASSERT_NEXT(a_hold_kept, i_clk, i_rst_n, (r_state == S_PUB) && r_hold_vld && out_busy, r_hold_vld && $stable(r_hold_freq) && (r_state == S_PUB))
    `CPFM_ASSERT_NOW(a_div_count, i_clk, i_rst_n, r_state == S_DIV, r_cnt < 6'(DIV_STEPS))

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Testbench of the capture period frequency meter
// Streams capture timestamps and publish ticks into the meter under several
// settings and idle patterns. A model of the per-channel period averaging
// computes the frequency reports that each tick must produce, and every
// output beat is checked against the oldest outstanding report.
// ----------------------------------------------------------------------------
module tb_top;
    import cpfm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 300;
    localparam int QUIET_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 800;
    localparam int LONG_RUN      = 24;

    typedef struct {
        logic        req;
        logic [1:0]  chan;
        logic [15:0] value;
    } t_meter_beat;

    typedef struct {
        logic [1:0]  chan;
        logic [31:0] freq_q8;
        logic        last;
    } t_freq_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;
    logic        o_m_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;

    capture_period_frequency_meter_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    t_meter_beat  pending_beats[$];
    t_freq_report freq_expect[$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  hold_requests  = 0;
    int  hold_served    = 0;
    int  hold_left      = 0;
    int  error_count    = 0;
    int  quiet_cycles   = 0;
    bit  beat_offered   = 1'b0;
    bit  s_took         = 1'b0;
    bit  m_took         = 1'b0;
    bit  cfg_took       = 1'b0;

    // Model of the meter state and its configuration.
    logic [3:0]  mdl_enable;
    logic [15:0] mdl_min_count;
    logic [23:0] mdl_rate_hz;
    logic [15:0] mdl_last_stamp[MAX_CHANNELS];
    bit          mdl_stamp_valid[MAX_CHANNELS];
    logic [31:0] mdl_period_sum[MAX_CHANNELS];
    logic [15:0] mdl_period_count[MAX_CHANNELS];

    function automatic void reset_meter_model();
        mdl_enable    = '0;
        mdl_min_count = 16'd1;
        mdl_rate_hz   = 24'd78125;
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            mdl_last_stamp[c]   = '0;
            mdl_stamp_valid[c]  = 1'b0;
            mdl_period_sum[c]   = '0;
            mdl_period_count[c] = '0;
        end
    endfunction

    function automatic logic [31:0] average_freq_q8(logic [31:0] sum, logic [15:0] count);
        logic [63:0] num;
        logic [63:0] quo;
        num = (64'(mdl_rate_hz) * 64'(count)) << 8;
        if (sum == '0) begin
            return '1;
        end
        quo = num / 64'(sum);
        if (quo > 64'h0000_0000_FFFF_FFFF) begin
            return '1;
        end
        return quo[31:0];
    endfunction

    function automatic void predict_meter_beat(t_meter_beat b);
        logic [15:0]  period;
        logic [32:0]  sum;
        t_freq_report rep;
        int           first;
        if (b.req == REQ_CAPTURE) begin
            if (!mdl_enable[b.chan]) begin
                return;
            end
            if (mdl_stamp_valid[b.chan]) begin
                period = b.value - mdl_last_stamp[b.chan];
                sum = {1'b0, mdl_period_sum[b.chan]} + 33'(period);
                mdl_period_sum[b.chan] = sum[32] ? '1 : sum[31:0];
                if (mdl_period_count[b.chan] != 16'hFFFF) begin
                    mdl_period_count[b.chan] = mdl_period_count[b.chan] + 16'd1;
                end
            end
            mdl_last_stamp[b.chan]  = b.value;
            mdl_stamp_valid[b.chan] = 1'b1;
            return;
        end
        first = freq_expect.size();
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            mdl_stamp_valid[c] = 1'b0;
        end
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            if (mdl_enable[c]) begin
                if (mdl_period_count[c] == '0) begin
                    mdl_period_sum[c] = '0;
                end else if (mdl_period_count[c] >= mdl_min_count) begin
                    rep.chan    = 2'(c);
                    rep.freq_q8 = average_freq_q8(mdl_period_sum[c], mdl_period_count[c]);
                    rep.last    = 1'b0;
                    freq_expect.push_back(rep);
                    mdl_period_sum[c]   = '0;
                    mdl_period_count[c] = '0;
                end
            end
        end
        if (freq_expect.size() > first) begin
            freq_expect[freq_expect.size() - 1].last = 1'b1;
        end
    endfunction

    // Input beat driver.
    always @(negedge i_clk) begin
        t_meter_beat nxt;
        if (!i_s_tvalid || s_took) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_beats.pop_front();
                beat_offered = 1'b1;
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= nxt.req;
                i_s_tdata  <= {6'd0, nxt.value, nxt.chan};
            end else begin
                beat_offered = 1'b0;
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Output side ready, with random stalls and a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left  = hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: prediction on accepted beats and checking of reports.
    always @(posedge i_clk) begin
        t_meter_beat  got_in;
        t_freq_report want;
        t_freq_report got;
        s_took   = i_rst_n && i_s_tvalid && o_s_tready;
        m_took   = i_rst_n && o_m_tvalid && i_m_tready;
        cfg_took = i_rst_n && i_cfg_valid && o_cfg_ready;
        if (!i_rst_n) begin
            reset_meter_model();
        end
        if (cfg_took) begin
            case (i_cfg_index)
                CFG_CHANNEL_ENABLE: mdl_enable    = i_cfg_data[3:0];
                CFG_MIN_COUNT:      mdl_min_count = i_cfg_data[15:0];
                CFG_TICK_RATE_HZ:   mdl_rate_hz   = i_cfg_data;
                default: ;
            endcase
        end
        if (s_took) begin
            got_in.req   = i_s_tuser;
            got_in.chan  = i_s_tdata[1:0];
            got_in.value = i_s_tdata[17:2];
            predict_meter_beat(got_in);
        end
        if (m_took) begin
            got.chan    = o_m_tdata[1:0];
            got.freq_q8 = o_m_tdata[33:2];
            got.last    = o_m_tlast;
            if (freq_expect.size() == 0) begin
                error_count++;
                $display("%0t: unexpected report beat: channel %0d freq %h last %b",
                         $time, got.chan, got.freq_q8, got.last);
            end else begin
                want = freq_expect.pop_front();
                if (got.chan !== want.chan || got.freq_q8 !== want.freq_q8
                        || got.last !== want.last) begin
                    error_count++;
                    $display({"%0t: report mismatch: expected channel %0d freq %h last %b,",
                              " got channel %0d freq %h last %b"},
                             $time, want.chan, want.freq_q8, want.last,
                             got.chan, got.freq_q8, got.last);
                end
            end
        end
        if (s_took || m_took || cfg_took) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do begin
            @(negedge i_clk);
        end while (!cfg_took);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        do begin
            @(negedge i_clk);
        end while (pending_beats.size() != 0 || beat_offered || freq_expect.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic push_capture(input logic [1:0] chan, input logic [15:0] value);
        t_meter_beat b;
        b.req   = REQ_CAPTURE;
        b.chan  = chan;
        b.value = value;
        pending_beats.push_back(b);
    endtask

    task automatic push_tick();
        t_meter_beat b;
        b.req   = REQ_TICK;
        b.chan  = 2'($urandom_range(3));
        b.value = 16'($urandom);
        pending_beats.push_back(b);
    endtask

    // Builds well-formed capture runs ended by a tick, with some stray beats.
    task automatic queue_capture_runs(input int n_beats);
        logic [15:0] stamp[MAX_CHANNELS];
        int          left[MAX_CHANNELS];
        int          mode[MAX_CHANNELS];
        int          total;
        int          added;
        int          c;
        t_meter_beat b;
        added = 0;
        while (added < n_beats) begin
            if ($urandom_range(99) < 15) begin
                b.req   = ($urandom_range(3) == 0) ? REQ_TICK : REQ_CAPTURE;
                b.chan  = 2'($urandom_range(3));
                b.value = 16'($urandom);
                pending_beats.push_back(b);
                added++;
            end else begin
                total = 0;
                for (c = 0; c < MAX_CHANNELS; c++) begin
                    left[c]  = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
                    mode[c]  = $urandom_range(2);
                    stamp[c] = 16'($urandom);
                    total += left[c];
                end
                while (total != 0) begin
                    c = $urandom_range(MAX_CHANNELS - 1);
                    if (left[c] != 0) begin
                        push_capture(2'(c), stamp[c]);
                        case (mode[c])
                            0:       stamp[c] = stamp[c] + 16'($urandom_range(31));
                            1:       stamp[c] = stamp[c] + 16'($urandom_range(200, 4000));
                            default: stamp[c] = stamp[c] + 16'($urandom);
                        endcase
                        left[c]--;
                        total--;
                        added++;
                    end
                end
                push_tick();
                added++;
            end
        end
    endtask

    initial begin
        int stall_mode[4][2];
        logic [15:0] stamp;
        stall_mode = '{'{0, 0}, '{80, 0}, '{0, 80}, '{6, 6}};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // Reset defaults of the minimum count and the timer rate.
        write_reg(CFG_CHANNEL_ENABLE, 24'hF);
        push_capture(2'd0, 16'd1000);
        push_capture(2'd0, 16'd1100);
        push_capture(2'd1, 16'd5);
        push_capture(2'd1, 16'd5);
        push_capture(2'd2, 16'hFFFF);
        push_capture(2'd2, 16'h0000);
        push_capture(2'd3, 16'hFFFF);
        push_capture(2'd3, 16'hFFFE);
        push_tick();
        push_tick();
        settle();

        // Highest rate: quotient saturation and a channel below the minimum.
        write_reg(CFG_MIN_COUNT, 24'd2);
        write_reg(CFG_TICK_RATE_HZ, 24'hFFFFFF);
        push_capture(2'd0, 16'd10);
        push_capture(2'd0, 16'd11);
        push_capture(2'd0, 16'd11);
        push_capture(2'd1, 16'd0);
        push_capture(2'd1, 16'd7);
        push_tick();
        push_capture(2'd1, 16'd20);
        push_capture(2'd1, 16'd27);
        push_tick();
        settle();

        // Disabled channels keep their sums; a minimum count of zero.
        write_reg(CFG_CHANNEL_ENABLE, 24'h5);
        write_reg(CFG_MIN_COUNT, 24'd0);
        write_reg(CFG_TICK_RATE_HZ, 24'd1);
        push_capture(2'd1, 16'd3);
        push_capture(2'd1, 16'd9);
        push_capture(2'd3, 16'd4);
        push_capture(2'd3, 16'd8);
        push_capture(2'd0, 16'd0);
        push_capture(2'd0, 16'hFFFF);
        push_capture(2'd0, 16'hFFFE);
        push_capture(2'd2, 16'd100);
        push_capture(2'd2, 16'd200);
        push_tick();
        settle();
        write_reg(CFG_CHANNEL_ENABLE, 24'hF);
        push_tick();
        settle();

        // Largest minimum count, then a run of the longest periods on one channel.
        write_reg(CFG_CHANNEL_ENABLE, 24'h1);
        write_reg(CFG_MIN_COUNT, 24'hFFFF);
        write_reg(CFG_TICK_RATE_HZ, 24'($urandom_range(1, 24'hFFFFFF)));
        push_capture(2'd0, 16'd50);
        push_capture(2'd0, 16'd60);
        push_capture(2'd0, 16'd75);
        push_tick();
        stamp = 16'($urandom);
        for (int k = 0; k < LONG_RUN; k++) begin
            push_capture(2'd0, stamp);
            stamp = stamp - 16'd1;
        end
        push_tick();
        settle();

        // Random traffic under each idle pattern.
        for (int p = 0; p < 4; p++) begin
            write_reg(CFG_CHANNEL_ENABLE, 24'($urandom_range(1, 15)));
            write_reg(CFG_MIN_COUNT, 24'(($urandom_range(9) == 0) ?
                      $urandom_range(1, 16'hFFFF) : $urandom_range(1, 4)));
            write_reg(CFG_TICK_RATE_HZ, 24'($urandom_range(1, 24'hFFFFFF)));
            send_idle_pct  = stall_mode[p][0];
            recv_stall_pct = stall_mode[p][1];
            queue_capture_runs(100);
            settle();
        end

        // Output held off for a long stretch while the input keeps coming.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(CFG_CHANNEL_ENABLE, 24'hF);
        write_reg(CFG_MIN_COUNT, 24'd1);
        write_reg(CFG_TICK_RATE_HZ, 24'd78125);
        hold_requests++;
        queue_capture_runs(40);
        settle();

        if (error_count == 0 && freq_expect.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
